/* design/ufe_pkg.sv */
// Shared types and constants for the union-find engine.
// Used by the channel interfaces, the controller, the datapath and the top level.
`default_nettype none

package ufe_pkg;

    localparam int ELEM_W           = 10;
    localparam int MODE_W           = 2;
    localparam int RANK_W           = 4;
    localparam int NUM_ELEMENTS_DEF = 1024;

    localparam logic [RANK_W-1:0] RANK_MAX = RANK_W'(15);

    // Operation codes carried by an input item
    localparam logic [MODE_W-1:0] MODE_UNION     = 2'd0;
    localparam logic [MODE_W-1:0] MODE_CONNECTED = 2'd1;
    localparam logic [MODE_W-1:0] MODE_FIND      = 2'd2;
    localparam logic [MODE_W-1:0] MODE_REINIT    = 2'd3;

    // Datapath commands
    localparam int DP_OP_W = 3;
    localparam logic [DP_OP_W-1:0] DP_NOP   = 3'd0;
    localparam logic [DP_OP_W-1:0] DP_LOAD  = 3'd1;
    localparam logic [DP_OP_W-1:0] DP_FIND  = 3'd2;
    localparam logic [DP_OP_W-1:0] DP_WALK  = 3'd3;
    localparam logic [DP_OP_W-1:0] DP_COMP  = 3'd4;
    localparam logic [DP_OP_W-1:0] DP_LINK  = 3'd5;
    localparam logic [DP_OP_W-1:0] DP_CLEAR = 3'd6;
    localparam logic [DP_OP_W-1:0] DP_OUT   = 3'd7;

    typedef struct packed {
        logic [DP_OP_W-1:0] op;
        logic               sel_b;   // find works on the second element
    } t_dp_cmd;

    typedef struct packed {
        logic              at_root;
        logic              comp_done;
        logic              op_oob;
        logic              clr_last;
        logic              out_hold;
        logic [MODE_W-1:0] mode;
    } t_dp_status;

endpackage

`default_nettype wire

/* design/ufe_in_if.sv */
// Input channel of the union-find engine: valid/ready plus one operation item.
// Depends on ufe_pkg.
`default_nettype none

interface ufe_in_if;
    import ufe_pkg::*;

    logic              valid;
    logic              ready;
    logic [MODE_W-1:0] mode;
    logic [ELEM_W-1:0] first_element;
    logic [ELEM_W-1:0] second_element;

    modport source (output valid, output mode, output first_element,
                    output second_element, input ready);
    modport sink   (input valid, input mode, input first_element,
                    input second_element, output ready);
endinterface

`default_nettype wire

/* design/ufe_out_if.sv */
// Result channel of the union-find engine: valid/ready plus one result item.
// Depends on ufe_pkg.
`default_nettype none

interface ufe_out_if;
    import ufe_pkg::*;

    logic              valid;
    logic              ready;
    logic [ELEM_W-1:0] first_root;
    logic              same_set;

    modport source (output valid, output first_root, output same_set, input ready);
    modport sink   (input valid, input first_root, input same_set, output ready);
endinterface

`default_nettype wire

/* design/ufe_datapath.sv */
// Datapath of the union-find engine: parent and rank memories, walk pointer,
// root registers, clearing counter and the result register. Depends on ufe_pkg.
`default_nettype none

module ufe_datapath #(
    parameter int NUM_ELEMENTS = ufe_pkg::NUM_ELEMENTS_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire ufe_pkg::t_dp_cmd            i_cmd,
    output ufe_pkg::t_dp_status              o_status,
    input  wire logic [ufe_pkg::MODE_W-1:0]  i_mode,
    input  wire logic [ufe_pkg::ELEM_W-1:0]  i_first_element,
    input  wire logic [ufe_pkg::ELEM_W-1:0]  i_second_element,
    output logic                             o_out_valid,
    input  wire logic                        i_out_ready,
    output logic [ufe_pkg::ELEM_W-1:0]       o_first_root,
    output logic                             o_same_set
);
    import ufe_pkg::*;

    // Only indices below 2**ELEM_W can ever be named, so store no more than that
    localparam int MEM_DEPTH = (NUM_ELEMENTS < (1 << ELEM_W)) ? NUM_ELEMENTS : (1 << ELEM_W);
    localparam int AW        = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
    localparam logic [AW-1:0] CLR_LAST = AW'(MEM_DEPTH - 1);

    function automatic logic elem_oob(input logic [ELEM_W-1:0] e);
        elem_oob = (32'(e) >= 32'(NUM_ELEMENTS));
    endfunction

    logic [ELEM_W-1:0] parent_mem [MEM_DEPTH];
    logic [RANK_W-1:0] rank_mem   [MEM_DEPTH];

    logic [MODE_W-1:0] r_mode;
    logic [ELEM_W-1:0] r_elem_a;
    logic [ELEM_W-1:0] r_elem_b;
    logic [ELEM_W-1:0] r_cur;
    logic [ELEM_W-1:0] r_ra;
    logic [ELEM_W-1:0] r_rb;
    logic [RANK_W-1:0] r_rank_a;
    logic [RANK_W-1:0] r_rank_b;
    logic              r_same;
    logic [ELEM_W-1:0] r_par_q;
    logic [RANK_W-1:0] r_rank_q;
    logic [AW-1:0]     r_clr;
    logic              r_out_valid;
    logic [ELEM_W-1:0] r_out_root;
    logic              r_out_same;

    logic [ELEM_W-1:0] operand;
    logic [ELEM_W-1:0] root_cur;
    logic              op_oob;
    logic              at_root;
    logic              comp_done;
    logic              out_hold;
    logic              do_link;
    logic              a_hi;
    logic [ELEM_W-1:0] lo;
    logic [ELEM_W-1:0] hi;
    logic [RANK_W-1:0] hi_rank;
    logic              bump;
    logic [AW-1:0]     rd_addr;
    logic              par_we;
    logic [AW-1:0]     par_wa;
    logic [ELEM_W-1:0] par_wd;
    logic              rank_we;
    logic [AW-1:0]     rank_wa;
    logic [RANK_W-1:0] rank_wd;

    assign operand   = i_cmd.sel_b ? r_elem_b : r_elem_a;
    assign root_cur  = i_cmd.sel_b ? r_rb : r_ra;
    assign op_oob    = elem_oob(operand);
    assign at_root   = (r_par_q == r_cur);
    assign comp_done = (r_cur == root_cur);
    assign out_hold  = r_out_valid && !i_out_ready;

    // Union by rank: on a tie the first root goes under the second
    assign a_hi    = (r_rank_a > r_rank_b);
    assign lo      = a_hi ? r_rb : r_ra;
    assign hi      = a_hi ? r_ra : r_rb;
    assign hi_rank = a_hi ? r_rank_a : r_rank_b;
    assign bump    = (r_rank_a == r_rank_b) && (hi_rank != RANK_MAX);
    assign do_link = (r_mode == MODE_UNION) && (r_ra != r_rb)
                     && !elem_oob(r_elem_a) && !elem_oob(r_elem_b);

    always_comb begin
        case (i_cmd.op)
            DP_FIND: rd_addr = operand[AW-1:0];
            DP_WALK: rd_addr = at_root ? operand[AW-1:0] : r_par_q[AW-1:0];
            default: rd_addr = r_par_q[AW-1:0];
        endcase
    end

    always_comb begin
        par_we  = 1'b0;
        par_wa  = r_clr;
        par_wd  = ELEM_W'(r_clr);
        rank_we = 1'b0;
        rank_wa = r_clr;
        rank_wd = '0;
        case (i_cmd.op)
            DP_COMP: begin
                par_we = !comp_done;
                par_wa = r_cur[AW-1:0];
                par_wd = root_cur;
            end
            DP_LINK: begin
                par_we  = do_link;
                par_wa  = lo[AW-1:0];
                par_wd  = hi;
                rank_we = do_link && bump;
                rank_wa = hi[AW-1:0];
                rank_wd = hi_rank + RANK_W'(1);
            end
            DP_CLEAR: begin
                par_we  = 1'b1;
                rank_we = 1'b1;
            end
            default: begin
                par_we  = 1'b0;
                rank_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (par_we) begin
            parent_mem[par_wa] <= par_wd;
        end
        r_par_q <= parent_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (rank_we) begin
            rank_mem[rank_wa] <= rank_wd;
        end
        r_rank_q <= rank_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            DP_LOAD: begin
                r_mode   <= i_mode;
                r_elem_a <= i_first_element;
                r_elem_b <= i_second_element;
            end
            DP_FIND: begin
                r_cur <= operand;
                // an element outside the forest is its own root
                if (op_oob) begin
                    if (i_cmd.sel_b) r_rb <= operand;
                    else             r_ra <= operand;
                end
            end
            DP_WALK: begin
                if (at_root) begin
                    if (i_cmd.sel_b) begin
                        r_rb     <= r_cur;
                        r_rank_b <= r_rank_q;
                    end else begin
                        r_ra     <= r_cur;
                        r_rank_a <= r_rank_q;
                    end
                    // restart from the element to compress the path
                    r_cur <= operand;
                end else begin
                    r_cur <= r_par_q;
                end
            end
            DP_COMP: begin
                if (!comp_done) r_cur <= r_par_q;
            end
            DP_LINK: begin
                r_same <= (r_ra == r_rb);
                if (do_link) r_ra <= hi;
            end
            DP_OUT: begin
                r_out_root <= (r_mode == MODE_REINIT) ? '0 : r_ra;
                r_out_same <= ((r_mode == MODE_UNION) || (r_mode == MODE_CONNECTED)) && r_same;
            end
            default: begin
                r_cur <= r_cur;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_clr       <= '0;
        end else begin
            if (i_cmd.op == DP_OUT) r_out_valid <= 1'b1;
            else if (i_out_ready)   r_out_valid <= 1'b0;
            if (i_cmd.op == DP_CLEAR) begin
                r_clr <= (r_clr == CLR_LAST) ? '0 : r_clr + AW'(1);
            end
        end
    end

    assign o_status.at_root   = at_root;
    assign o_status.comp_done = comp_done;
    assign o_status.op_oob    = op_oob;
    assign o_status.clr_last  = (r_clr == CLR_LAST);
    assign o_status.out_hold  = out_hold;
    assign o_status.mode      = r_mode;

    assign o_out_valid  = r_out_valid;
    assign o_first_root = r_out_root;
    assign o_same_set   = r_out_same;

    a_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.op == DP_OUT |-> !out_hold)
        else $error("result register overwritten while stalled");

    a_out_shown: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.op == DP_OUT |=> r_out_valid)
        else $error("result not presented after load");

    a_link_distinct: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == DP_LINK) && do_link |-> (lo != hi) && (r_mode == MODE_UNION))
        else $error("root linked under itself");

endmodule

`default_nettype wire

/* design/ufe_controller.sv */
// Controller of the union-find engine: sequences finds, path compression,
// linking, clearing sweeps and result hand-off. Depends on ufe_pkg.
`default_nettype none

module ufe_controller (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_in_valid,
    input  wire logic [ufe_pkg::MODE_W-1:0]  i_in_mode,
    output logic                             o_in_ready,
    output ufe_pkg::t_dp_cmd                 o_cmd,
    input  wire ufe_pkg::t_dp_status         i_status
);
    import ufe_pkg::*;

    localparam logic [2:0] S_CLEAR  = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_FIND   = 3'd2;
    localparam logic [2:0] S_WALK   = 3'd3;
    localparam logic [2:0] S_COMP   = 3'd4;
    localparam logic [2:0] S_LINK   = 3'd5;
    localparam logic [2:0] S_RESULT = 3'd6;

    logic [2:0] r_state, n_state;
    logic       r_second, n_second;
    logic       r_pend, n_pend;
    logic       find_done;

    always_comb begin
        n_state     = r_state;
        n_second    = r_second;
        n_pend      = r_pend;
        o_cmd.op    = DP_NOP;
        o_cmd.sel_b = r_second;
        o_in_ready  = 1'b0;
        find_done   = 1'b0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.op = DP_CLEAR;
                if (i_status.clr_last) begin
                    n_pend  = 1'b0;
                    n_state = r_pend ? S_RESULT : S_IDLE;
                end
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.op = DP_LOAD;
                    n_second = 1'b0;
                    if (i_in_mode == MODE_REINIT) begin
                        n_pend  = 1'b1;
                        n_state = S_CLEAR;
                    end else begin
                        n_state = S_FIND;
                    end
                end
            end
            S_FIND: begin
                o_cmd.op = DP_FIND;
                if (i_status.op_oob) find_done = 1'b1;
                else                 n_state   = S_WALK;
            end
            S_WALK: begin
                o_cmd.op = DP_WALK;
                if (i_status.at_root) n_state = S_COMP;
            end
            S_COMP: begin
                o_cmd.op = DP_COMP;
                if (i_status.comp_done) find_done = 1'b1;
            end
            S_LINK: begin
                o_cmd.op = DP_LINK;
                n_state  = S_RESULT;
            end
            S_RESULT: begin
                // hold until the result register is free
                if (!i_status.out_hold) begin
                    o_cmd.op = DP_OUT;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (find_done) begin
            if (i_status.mode == MODE_FIND) begin
                n_state = S_RESULT;
            end else if (!r_second) begin
                n_second = 1'b1;
                n_state  = S_FIND;
            end else begin
                n_state = S_LINK;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_second <= 1'b0;
            r_pend   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_second <= n_second;
            r_pend   <= n_pend;
        end
    end

    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) && i_in_valid |=> (r_state != S_IDLE))
        else $error("accepted item not started");

    a_clear_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) && i_status.clr_last |=> (r_state != S_CLEAR))
        else $error("clearing sweep did not end");

    a_link_after_second: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LINK) |-> r_second && (i_status.mode != MODE_FIND))
        else $error("link reached without both roots");

endmodule

`default_nettype wire

/* design/union_find_engine_top.sv */
// Union-find engine top level: disjoint-set forest with union by rank and
// path compression. Depends on ufe_pkg, ufe_in_if, ufe_out_if, ufe_controller
// and ufe_datapath.
//
// Usage: i_item carries mode, first_element and second_element; o_result
// returns first_root and same_set, one result per item, in order. Both use
// valid/ready; an item moves on a clock edge with valid and ready high.
// Items are handled one at a time. A find walks the parent chain at one node
// per cycle and then rewrites it at one node per cycle; the chain is at most
// as long as the tree rank, roughly log2 of set size. Reinitialize clears one
// memory entry per cycle. After reset the block clears all MEM_DEPTH entries,
// min(NUM_ELEMENTS, 1024), of both memories with i_item.ready low. A finished
// result sits in an output register; while the receiver stalls the block
// still takes and works the next item, and holds it at the end until the
// register frees.
`default_nettype none

module union_find_engine_top #(
    parameter int NUM_ELEMENTS = ufe_pkg::NUM_ELEMENTS_DEF
) (
    input wire logic i_clk,
    input wire logic i_rst_n,
    ufe_in_if.sink   i_item,
    ufe_out_if.source o_result
);
    import ufe_pkg::*;

    t_dp_cmd    dp_cmd;
    t_dp_status dp_status;

    ufe_controller u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_item.valid),
        .i_in_mode  (i_item.mode),
        .o_in_ready (i_item.ready),
        .o_cmd      (dp_cmd),
        .i_status   (dp_status)
    );

    ufe_datapath #(
        .NUM_ELEMENTS (NUM_ELEMENTS)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (dp_cmd),
        .o_status         (dp_status),
        .i_mode           (i_item.mode),
        .i_first_element  (i_item.first_element),
        .i_second_element (i_item.second_element),
        .o_out_valid      (o_result.valid),
        .i_out_ready      (o_result.ready),
        .o_first_root     (o_result.first_root),
        .o_same_set       (o_result.same_set)
    );

endmodule

`default_nettype wire

/* verif/forest_checker.sv */
`timescale 1ns / 1ps
// Forest checker: keeps its own disjoint-set forest, predicts root and same-set flag
// for every accepted item and compares them in order with the result channel.
// Depends on ufe_pkg, ufe_in_if and ufe_out_if.

module forest_checker #(
    parameter int NUM_ELEMENTS = ufe_pkg::NUM_ELEMENTS_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    ufe_in_if    in_ch,
    ufe_out_if   out_ch,
    output int   o_mismatches,
    output int   o_pending
);
    import ufe_pkg::*;

    typedef struct packed {
        logic [ELEM_W-1:0] root;
        logic              same;
    } t_outcome;

    logic [ELEM_W-1:0] parent_mirror [NUM_ELEMENTS];
    logic [RANK_W-1:0] rank_mirror   [NUM_ELEMENTS];
    t_outcome          outcome_queue [$];
    int                mismatch_count = 0;

    initial begin
        o_mismatches = 0;
        o_pending    = 0;
    end

    function automatic void clear_forest();
        for (int k = 0; k < NUM_ELEMENTS; k++) begin
            parent_mirror[k] = ELEM_W'(k);
            rank_mirror[k]   = '0;
        end
    endfunction

    // Walk to the root, then point every node on the path straight at it
    function automatic logic [ELEM_W-1:0] find_root(input logic [ELEM_W-1:0] e);
        logic [ELEM_W-1:0] r;
        logic [ELEM_W-1:0] w;
        logic [ELEM_W-1:0] nx;
        int                steps;
        if (int'(e) >= NUM_ELEMENTS) return e;
        r     = e;
        steps = 0;
        while (parent_mirror[r] != r && steps < NUM_ELEMENTS) begin
            r = parent_mirror[r];
            steps++;
        end
        w     = e;
        steps = 0;
        while (w != r && steps < NUM_ELEMENTS) begin
            nx               = parent_mirror[w];
            parent_mirror[w] = r;
            w                = nx;
            steps++;
        end
        return r;
    endfunction

    function automatic t_outcome predict_outcome(input logic [MODE_W-1:0] mode,
                                                 input logic [ELEM_W-1:0] a,
                                                 input logic [ELEM_W-1:0] b);
        t_outcome          res;
        logic [ELEM_W-1:0] ra;
        logic [ELEM_W-1:0] rb;
        logic [ELEM_W-1:0] lo;
        logic [ELEM_W-1:0] hi;
        res = '0;
        case (mode)
            MODE_UNION, MODE_CONNECTED: begin
                ra       = find_root(a);
                rb       = find_root(b);
                res.same = (ra == rb);
                res.root = ra;
                if (mode == MODE_UNION && !res.same &&
                    int'(ra) < NUM_ELEMENTS && int'(rb) < NUM_ELEMENTS) begin
                    lo = ra;
                    hi = rb;
                    if (rank_mirror[lo] > rank_mirror[hi]) begin
                        lo = rb;
                        hi = ra;
                    end
                    // equal ranks: the surviving root grows, saturating at the top
                    if (rank_mirror[lo] == rank_mirror[hi] && rank_mirror[hi] < RANK_MAX)
                        rank_mirror[hi] = rank_mirror[hi] + 1'b1;
                    parent_mirror[lo] = hi;
                    res.root          = hi;
                end
            end
            MODE_FIND: begin
                res.root = find_root(a);
            end
            default: begin
                clear_forest();
            end
        endcase
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_outcome seen;
        t_outcome want;
        if (!i_rst_n) begin
            clear_forest();
            outcome_queue.delete();
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                seen.root = out_ch.first_root;
                seen.same = out_ch.same_set;
                if (outcome_queue.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("%0t: result with nothing expected: root %0d same %0d",
                                 $realtime, seen.root, seen.same);
                end else begin
                    want = outcome_queue.pop_front();
                    if (want.root !== seen.root || want.same !== seen.same) begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("%0t: mismatch: root exp %0d got %0d, same exp %0d got %0d",
                                     $realtime, want.root, seen.root, want.same, seen.same);
                    end
                end
            end
            // append the prediction at the tail of the queue
            if (in_ch.valid && in_ch.ready)
                outcome_queue.insert(outcome_queue.size(),
                                     predict_outcome(in_ch.mode, in_ch.first_element,
                                                     in_ch.second_element));
        end
        o_pending    <= outcome_queue.size();
        o_mismatches <= mismatch_count;
    end

endmodule

/* verif/tb.sv */
`timescale 1ns / 1ps
// Testbench top for the union-find engine: clock, reset, item stimulus with random gaps,
// random result back-pressure and the final verdict. Depends on ufe_pkg, the channel
// interfaces, union_find_engine_top and forest_checker.

module tb;
    import ufe_pkg::*;

    localparam int CYCLE_LIMIT = 600000;

    logic i_clk;
    logic i_rst_n;
    int   mismatches;
    int   outstanding;
    int   cycle_count = 0;
    bit   quiet       = 1'b0;

    ufe_in_if  item_ch ();
    ufe_out_if result_ch ();

    union_find_engine_top dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (item_ch),
        .o_result (result_ch)
    );

    forest_checker forest_chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .in_ch        (item_ch),
        .out_ch       (result_ch),
        .o_mismatches (mismatches),
        .o_pending    (outstanding)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Result back-pressure: stall about one cycle in five outside the quiet stretch
    always @(posedge i_clk) begin
        if (!i_rst_n)
            result_ch.ready <= 1'b0;
        else
            result_ch.ready <= quiet ? 1'b1 : ($urandom_range(99) >= 20);
    end

    // Returns at the edge where the item is accepted
    task automatic send_item(input logic [MODE_W-1:0] mode,
                             input logic [ELEM_W-1:0] a,
                             input logic [ELEM_W-1:0] b);
        while (!quiet && $urandom_range(99) < 20) begin
            item_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        item_ch.valid          <= 1'b1;
        item_ch.mode           <= mode;
        item_ch.first_element  <= a;
        item_ch.second_element <= b;
        do @(posedge i_clk); while (!item_ch.ready);
    endtask

    task automatic drain_results();
        item_ch.valid <= 1'b0;
        do @(posedge i_clk); while (outstanding != 0);
    endtask

    initial begin
        logic [MODE_W-1:0] mode;
        logic [ELEM_W-1:0] a;
        logic [ELEM_W-1:0] b;
        int                pool_base;
        int                pool_size;
        int                pick;

        item_ch.valid          <= 1'b0;
        item_ch.mode           <= MODE_FIND;
        item_ch.first_element  <= '0;
        item_ch.second_element <= '0;
        i_rst_n                <= 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: field extremes, every operation, rank growth, compression, reinit
        send_item(MODE_FIND,      10'd0,    10'd1023);
        send_item(MODE_FIND,      10'd1023, 10'd0);
        send_item(MODE_CONNECTED, 10'd0,    10'd1023);
        send_item(MODE_UNION,     10'd0,    10'd1023);
        send_item(MODE_CONNECTED, 10'd1023, 10'd0);
        send_item(MODE_UNION,     10'd0,    10'd1023);
        send_item(MODE_UNION,     10'd5,    10'd5);
        send_item(MODE_UNION,     10'd1,    10'd2);
        send_item(MODE_UNION,     10'd3,    10'd4);
        send_item(MODE_UNION,     10'd1,    10'd3);
        send_item(MODE_UNION,     10'd5,    10'd6);
        send_item(MODE_UNION,     10'd7,    10'd8);
        send_item(MODE_UNION,     10'd5,    10'd7);
        send_item(MODE_UNION,     10'd1,    10'd5);
        send_item(MODE_UNION,     10'd1022, 10'd2);
        send_item(MODE_FIND,      10'd1,    10'd682);
        send_item(MODE_FIND,      10'd8,    10'd341);
        send_item(MODE_CONNECTED, 10'd2,    10'd8);
        send_item(MODE_CONNECTED, 10'd3,    10'd1021);
        send_item(MODE_REINIT,    10'd1023, 10'd1023);
        send_item(MODE_FIND,      10'd2,    10'd0);
        send_item(MODE_CONNECTED, 10'd1,    10'd2);
        send_item(MODE_UNION,     10'd1022, 10'd1021);
        send_item(MODE_FIND,      10'd1021, 10'd0);

        // Random: mostly unions and queries inside a small pool so trees grow deep
        pool_base = 0;
        pool_size = 16;
        for (int n = 0; n < 650; n++) begin
            quiet = (n >= 300 && n < 420);
            if (n == 200) drain_results();
            if (n % 100 == 0) begin
                pool_size = $urandom_range(8, 64);
                pool_base = $urandom_range(0, 1024 - pool_size);
            end
            pick = $urandom_range(99);
            if (pick < 2)
                mode = MODE_REINIT;
            else if (pick < 50)
                mode = MODE_UNION;
            else if (pick < 75)
                mode = MODE_CONNECTED;
            else
                mode = MODE_FIND;
            if ($urandom_range(99) < 25) begin
                a = ELEM_W'($urandom);
                b = ELEM_W'($urandom);
            end else begin
                a = ELEM_W'(pool_base + $urandom_range(pool_size - 1));
                b = ELEM_W'(pool_base + $urandom_range(pool_size - 1));
            end
            send_item(mode, a, b);
        end
        quiet = 1'b0;

        drain_results();
        repeat (40) @(posedge i_clk);
        if (mismatches == 0 && outstanding == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
